[sv/mbps_pkg.sv]
// Shared constants, types and register codes for the masked byte pattern search.
package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int REG_BYTES       = 32;
    localparam int REG_WORDS       = 4;
    localparam int WORD_W          = 64;
    localparam int ADDR_W          = 64;
    localparam int LEN_W           = 6;
    localparam int IDX_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0 = 3'd0,
        REG_PATTERN_1 = 3'd1,
        REG_PATTERN_2 = 3'd2,
        REG_PATTERN_3 = 3'd3,
        REG_CARE_MASK = 3'd4,
        REG_PAT_LEN   = 3'd5,
        REG_BASE_ADDR = 3'd6
    } cfg_reg_e;

    // Compare settings that every cell of the window sees.
    typedef struct packed {
        logic [REG_BYTES*8-1:0] pattern;
        logic [REG_BYTES-1:0]   care;
        logic [LEN_W-1:0]       len;
    } cmp_cfg_t;

endpackage

[sv/mbps_ifs.sv]
// Handshake interfaces for the scan, result and configuration channels.
interface mbps_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_result_if
    import mbps_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink (input valid, input found, input match_address, output ready);
endinterface

interface mbps_cfg_if
    import mbps_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/mbps_cfg_regs.sv]
// Configuration register file with pattern length saturation.
module mbps_cfg_regs
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mbps_cfg_if.sink          cfg,
    output cmp_cfg_t          cmp_cfg,
    output logic [ADDR_W-1:0] base_address
);

    localparam int LIMIT = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LIMIT);

    logic [REG_BYTES*8-1:0] pattern_reg;
    logic [REG_BYTES-1:0]   care_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [ADDR_W-1:0]      base_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            care_reg    <= '0;
            len_reg     <= LEN_RESET;
            base_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_e'(cfg.index))
                REG_PATTERN_0: pattern_reg[0*WORD_W +: WORD_W] <= cfg.data;
                REG_PATTERN_1: pattern_reg[1*WORD_W +: WORD_W] <= cfg.data;
                REG_PATTERN_2: pattern_reg[2*WORD_W +: WORD_W] <= cfg.data;
                REG_PATTERN_3: pattern_reg[3*WORD_W +: WORD_W] <= cfg.data;
                REG_CARE_MASK: care_reg <= cfg.data[REG_BYTES-1:0];
                REG_PAT_LEN:   len_reg <= cfg.data[LEN_W-1:0];
                REG_BASE_ADDR: base_reg <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Lengths beyond what the window and pattern hold are clipped.
    always_comb
    begin
        cmp_cfg.pattern = pattern_reg;
        cmp_cfg.care    = care_reg;
        cmp_cfg.len     = (len_reg > LEN_LIMIT) ? LEN_LIMIT : len_reg;
    end

    assign base_address = base_reg;

endmodule

[sv/mbps_cell.sv]
// One window cell: holds one byte, passes it on, and checks it against its pattern byte.
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int K = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       advance,
    input  logic [7:0] byte_in,
    input  cmp_cfg_t   cmp_cfg,
    output logic [7:0] byte_out,
    output logic       ok
);

    localparam logic [LEN_W:0]   K_WIDE = (LEN_W+1)'(K);
    localparam logic [LEN_W-1:0] K_NEXT = LEN_W'(K + 1);

    logic [7:0]       byte_reg;
    logic             ok_reg;
    logic             ok_next;
    logic             in_use;
    logic [LEN_W-1:0] pos;
    logic [IDX_W-1:0] sel;
    logic [7:0]       pat_byte;

    // Cell K sits K bytes back from the newest, so it meets pattern byte len-1-K.
    always_comb
    begin
        in_use   = K_WIDE < {1'b0, cmp_cfg.len};
        pos      = cmp_cfg.len - K_NEXT;
        sel      = pos[IDX_W-1:0];
        pat_byte = cmp_cfg.pattern[sel*8 +: 8];
        ok_next  = !in_use || !cmp_cfg.care[sel] || (pat_byte == byte_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
            ok_reg   <= 1'b1;
        end
        else
        begin
            if (shift_en)
            begin
                byte_reg <= byte_in;
            end
            if (advance)
            begin
                ok_reg <= ok_next;
            end
        end
    end

    assign byte_out = byte_reg;
    assign ok       = ok_reg;

endmodule

[sv/masked_byte_pattern_search.sv]
// Pipeline: a byte accepted from the scan channel passes through the window, compare and output
// registers in that order before its result can be taken.
// Throughput: one byte per cycle; the input stalls only while a result waits and is not taken.
// The rate is set by the cell row, which shifts and compares one byte per cycle in parallel.
// Reset clears the window, the byte count, the match flag and the pipeline valid bits.
// Reset registers go to zero except the pattern length and cell match bits, which reset to one.
module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mbps_scan_if.sink     scan,
    mbps_result_if.source result,
    mbps_cfg_if.sink      cfg
);

    // Configuration registers feed every cell through one struct.
    cmp_cfg_t          cmp_cfg;
    logic [ADDR_W-1:0] base_address;

    mbps_cfg_regs #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmp_cfg     (cmp_cfg),
        .base_address(base_address)
    );

    // The whole pipeline moves together; it holds only when the output register is
    // full and the consumer does not take the word.
    logic en;
    logic scan_acc;
    logic out_valid_reg;

    assign en         = !(out_valid_reg && !result.ready);
    assign scan.ready = en;
    assign scan_acc   = scan.valid && en;

    // Stage one: the cell row holds the window after the newest byte, and the
    // byte count runs alongside. The window is never cleared between scans: a
    // compare only looks at positions below the count, which are all from this scan.
    logic [7:0]         win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] ok_bits;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [7:0] feed;
            if (k == 0)
            begin : g_head
                assign feed = scan.data_byte;
            end
            else
            begin : g_body
                assign feed = win[k-1];
            end
            mbps_cell #(
                .K(k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift_en(scan_acc),
                .advance (en),
                .byte_in (feed),
                .cmp_cfg (cmp_cfg),
                .byte_out(win[k]),
                .ok      (ok_bits[k])
            );
        end
    endgenerate

    logic [ADDR_W-1:0] count_reg;
    logic [ADDR_W-1:0] count_next;
    logic              restart_reg;
    logic              s1_valid_reg;
    logic              s1_last_reg;

    // The first byte after a last byte starts a fresh count.
    assign count_next = restart_reg ? ADDR_W'(1) : count_reg + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            restart_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= scan.valid;
            if (scan.valid)
            begin
                count_reg   <= count_next;
                restart_reg <= scan.last_byte;
                s1_last_reg <= scan.last_byte;
            end
        end
    end

    // Stage two: the cells have registered their compare bits; the count and the
    // last flag travel with them.
    logic [ADDR_W-1:0] s2_count_reg;
    logic              s2_valid_reg;
    logic              s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_count_reg <= count_reg;
        end
    end

    // A hit needs a nonzero length, enough bytes of this scan, and every cell agreeing.
    logic              enough;
    logic              hit;
    logic              emit;
    logic              match_done_reg;
    logic              match_done_next;
    logic [ADDR_W-1:0] start_address;

    always_comb
    begin
        enough = (s2_count_reg[ADDR_W-1:LEN_W] != '0) ||
                 (s2_count_reg[LEN_W-1:0] >= cmp_cfg.len);
        hit    = (cmp_cfg.len != '0) && enough && (&ok_bits);
        // Only the first hit of a scan reports; a scan with none reports on its last byte.
        emit   = s2_valid_reg && !match_done_reg && (hit || s2_last_reg);
        start_address = base_address + s2_count_reg - ADDR_W'(cmp_cfg.len);
        if (s2_valid_reg && s2_last_reg)
        begin
            match_done_next = 1'b0;
        end
        else
        begin
            match_done_next = match_done_reg || (s2_valid_reg && hit);
        end
    end

    // Output register.
    logic              found_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            match_done_reg <= match_done_next;
            out_valid_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && emit)
        begin
            found_reg <= hit;
            addr_reg  <= hit ? start_address : '0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.found         = found_reg;
    assign result.match_address = addr_reg;

    // A miss result always carries a zero address.
    a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> addr_reg == '0)
        else $error("miss result with nonzero address");

    // A hit that does not close the scan blocks later reports of the same scan.
    a_hit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        en && s2_valid_reg && hit && !s2_last_reg |=> match_done_reg)
        else $error("match flag not set after a hit");

    // A byte that neither hits nor ends the scan produces no word.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        en && s2_valid_reg && !s2_last_reg && !hit |=> !out_valid_reg)
        else $error("result word without hit or end of scan");

    // The first byte of a new scan counts as one.
    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        scan_acc && restart_reg |=> count_reg == ADDR_W'(1))
        else $error("byte count did not restart");

endmodule
